// ===== rtl/core/cmap_pkg.sv =====
// cmap_pkg: shared types, constants and byte helpers for the max-age parser
// no dependencies; used by cmap_token and cache_control_max_age_parser
package cmap_pkg;

  localparam int unsigned ValW    = 63;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned KeyIdxW = 3;

  localparam logic [ByteW-1:0] ChComma = 8'h2C;
  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_PREFIX,
    PH_VALUE,
    PH_TRAIL,
    PH_DEAD
  } phase_e;

  // per-token parse state
  typedef struct packed {
    phase_e              phase;
    logic [KeyIdxW-1:0]  key_idx;
    logic [ValW-1:0]     acc;
    logic                minus_seen;
    logic                digits_seen;
  } tok_t;

  // one input item as it travels to the parse stage
  typedef struct packed {
    logic [ByteW-1:0] header_byte;
    logic             byte_valid;
    logic             end_of_header;
  } item_t;

  localparam tok_t TokClear = '{
    phase:       PH_LEAD,
    key_idx:     '0,
    acc:         '0,
    minus_seen:  1'b0,
    digits_seen: 1'b0
  };

  function automatic logic is_blank(logic [ByteW-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [ByteW-1:0] fold_lower(logic [ByteW-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
  endfunction

  // "max-age=" one character per prefix position
  function automatic logic [ByteW-1:0] key_char(logic [KeyIdxW-1:0] idx);
    logic [ByteW-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h6D;
      3'd1:    ch = 8'h61;
      3'd2:    ch = 8'h78;
      3'd3:    ch = 8'h2D;
      3'd4:    ch = 8'h61;
      3'd5:    ch = 8'h67;
      3'd6:    ch = 8'h65;
      3'd7:    ch = 8'h3D;
      default: ch = 8'h3D;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/cmap_in_if.sv =====
// cmap_in_if: valid/ready channel carrying one header byte per transfer
// depends on nothing
interface cmap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       byte_valid;
  logic       end_of_header;

  modport source (output valid, header_byte, byte_valid, end_of_header, input ready);
  modport sink   (input valid, header_byte, byte_valid, end_of_header, output ready);
endinterface

// ===== rtl/core/cmap_out_if.sv =====
// cmap_out_if: valid/ready channel carrying one parsed max-age result
// depends on nothing
interface cmap_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] max_age_seconds;

  modport source (output valid, max_age_seconds, input ready);
  modport sink   (input valid, max_age_seconds, output ready);
endinterface

// ===== rtl/core/cmap_token.sv =====
// cmap_token: token state machine; consumes one item per enabled cycle
// depends on cmap_pkg
module cmap_token (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  cmap_pkg::item_t             item_i,
  output logic                        res_valid_o,
  output logic [cmap_pkg::ValW-1:0]   res_value_o
);

  cmap_pkg::tok_t                tok_q, tok_d, tok_b;
  logic                          found_q, found_d, found_b;
  logic [cmap_pkg::ValW-1:0]     ans_q, ans_d, ans_b;

  logic [cmap_pkg::ByteW-1:0]    c;
  logic                          is_digit;
  logic [3:0]                    digit;
  logic [cmap_pkg::ValW+3:0]     acc_next;
  logic                          ovf;
  logic                          key_hit;
  logic                          close_ok;

  assign c        = item_i.header_byte;
  assign is_digit = (c >= cmap_pkg::ChZero) && (c <= cmap_pkg::ChNine);
  assign digit    = c[3:0];
  // acc*10 + digit, checked against 2^63-1
  assign acc_next = {1'b0, tok_q.acc, 3'b000} + {3'b000, tok_q.acc, 1'b0}
                  + {{cmap_pkg::ValW{1'b0}}, digit};
  assign ovf      = |acc_next[cmap_pkg::ValW+3:cmap_pkg::ValW];
  assign key_hit  = (cmap_pkg::fold_lower(c) == cmap_pkg::key_char(tok_q.key_idx));

  // effect of the byte itself
  always_comb begin
    tok_b   = tok_q;
    found_b = found_q;
    ans_b   = ans_q;
    if (item_i.byte_valid && !found_q) begin
      if (c == cmap_pkg::ChComma) begin
        if (tok_q.digits_seen &&
            (tok_q.phase == cmap_pkg::PH_VALUE || tok_q.phase == cmap_pkg::PH_TRAIL)) begin
          found_b = 1'b1;
          ans_b   = tok_q.acc;
        end
        tok_b = cmap_pkg::TokClear;
      end else begin
        case (tok_q.phase)
          cmap_pkg::PH_LEAD, cmap_pkg::PH_PREFIX: begin
            if (tok_q.phase == cmap_pkg::PH_LEAD && cmap_pkg::is_blank(c)) begin
              tok_b.phase = cmap_pkg::PH_LEAD;
            end else if (key_hit) begin
              tok_b.key_idx = tok_q.key_idx + 3'd1;
              tok_b.phase   = (&tok_q.key_idx) ? cmap_pkg::PH_VALUE : cmap_pkg::PH_PREFIX;
            end else begin
              tok_b.phase = cmap_pkg::PH_DEAD;
            end
          end
          cmap_pkg::PH_VALUE: begin
            if (is_digit) begin
              if ((tok_q.minus_seen && digit != 4'd0) || ovf) begin
                tok_b.phase = cmap_pkg::PH_DEAD;
              end else begin
                tok_b.acc         = acc_next[cmap_pkg::ValW-1:0];
                tok_b.digits_seen = 1'b1;
              end
            end else if (c == cmap_pkg::ChMinus && !tok_q.minus_seen && !tok_q.digits_seen) begin
              tok_b.minus_seen = 1'b1;
            end else if (cmap_pkg::is_blank(c) && tok_q.digits_seen) begin
              tok_b.phase = cmap_pkg::PH_TRAIL;
            end else begin
              tok_b.phase = cmap_pkg::PH_DEAD;
            end
          end
          cmap_pkg::PH_TRAIL: begin
            if (!cmap_pkg::is_blank(c)) begin
              tok_b.phase = cmap_pkg::PH_DEAD;
            end
          end
          default: tok_b.phase = cmap_pkg::PH_DEAD;
        endcase
      end
    end
  end

  // last token judged at the end of the header
  assign close_ok = tok_b.digits_seen &&
                    (tok_b.phase == cmap_pkg::PH_VALUE || tok_b.phase == cmap_pkg::PH_TRAIL);

  // next state
  always_comb begin
    tok_d   = tok_q;
    found_d = found_q;
    ans_d   = ans_q;
    if (en_i) begin
      if (item_i.end_of_header) begin
        tok_d   = cmap_pkg::TokClear;
        found_d = 1'b0;
        ans_d   = '0;
      end else begin
        tok_d   = tok_b;
        found_d = found_b;
        ans_d   = ans_b;
      end
    end
  end

  // outputs
  always_comb begin
    res_valid_o = en_i && item_i.end_of_header;
    if (found_b) begin
      res_value_o = ans_b;
    end else if (close_ok) begin
      res_value_o = tok_b.acc;
    end else begin
      res_value_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= cmap_pkg::TokClear;
      found_q <= 1'b0;
      ans_q   <= '0;
    end else begin
      tok_q   <= tok_d;
      found_q <= found_d;
      ans_q   <= ans_d;
    end
  end

endmodule

// ===== rtl/core/cache_control_max_age_parser.sv =====
// Streaming max-age parser for a Cache-Control header value. One byte is taken per transfer on
// hdr_i; the item with end_of_header set yields one result on res_o, the first well-formed
// non-negative "max-age=<digits>" token's value or 0. Each item is held in the input register
// and is parsed on its way into the result register, which drives res_o. A new item is taken every
// cycle; only an end item waits on a full result register, and it holds the input until that
// result is transferred.
// depends on cmap_pkg, cmap_in_if, cmap_out_if, cmap_token
module cache_control_max_age_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  cmap_in_if.sink      hdr_i,
  cmap_out_if.source   res_o
);

  cmap_pkg::item_t               item_q;
  logic                          item_vld_q;
  logic                          advance;
  logic                          res_vld_q;
  logic [cmap_pkg::ValW-1:0]     res_val_q;
  logic                          tok_res_vld;
  logic [cmap_pkg::ValW-1:0]     tok_res_val;

  // an end item needs a free result slot; other items never wait
  assign advance     = item_vld_q &&
                       (!item_q.end_of_header || !res_vld_q || res_o.ready);
  assign hdr_i.ready = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (hdr_i.ready) begin
      item_vld_q <= hdr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_i.valid && hdr_i.ready) begin
      item_q.header_byte   <= hdr_i.header_byte;
      item_q.byte_valid    <= hdr_i.byte_valid;
      item_q.end_of_header <= hdr_i.end_of_header;
    end
  end

  cmap_token u_token (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .item_i      (item_q),
    .res_valid_o (tok_res_vld),
    .res_value_o (tok_res_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (tok_res_vld) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_res_vld) begin
      res_val_q <= tok_res_val;
    end
  end

  assign res_o.valid           = res_vld_q;
  assign res_o.max_age_seconds = res_val_q;

endmodule

// ===== rtl/core/cmap_checker.sv =====
// cmap_checker: port-level assertions for the max-age parser, bound to the top level
// depends on cache_control_max_age_parser
module cmap_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_eoh_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [62:0] out_data_i
);

  logic [1:0] pending_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // end items taken whose result has not yet been transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else begin
      pending_q <= pending_q + {1'b0, in_xfer && in_eoh_i} - {1'b0, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("result without a finished header");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more finished headers in flight than storage allows");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 2'd2 && !out_ready_i |-> !(in_xfer && in_eoh_i))
    else $error("end item taken with both stages holding results");

endmodule

bind cache_control_max_age_parser cmap_checker u_cmap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (hdr_i.valid),
  .in_ready_i  (hdr_i.ready),
  .in_eoh_i    (hdr_i.end_of_header),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_data_i  (res_o.max_age_seconds)
);
